// ===== hdl/pip_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pip_pkg;

   // Outcome of one edge test against the downward ray.
   typedef struct packed {
      logic crossing;   // edge crosses the ray: toggle parity
      logic vertical;   // vertical edge through the point
   } edge_result_type;

endpackage

`default_nettype wire

// ===== hdl/pip_edge_test.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pip_edge_test #(
   parameter int COORD_WIDTH = 16
) (
   input  wire logic signed [COORD_WIDTH-1:0] ax,
   input  wire logic signed [COORD_WIDTH-1:0] ay,
   input  wire logic signed [COORD_WIDTH-1:0] bx,
   input  wire logic signed [COORD_WIDTH-1:0] by,
   input  wire logic signed [COORD_WIDTH-1:0] px,
   input  wire logic signed [COORD_WIDTH-1:0] py,
   output pip_pkg::edge_result_type           result
);
   import pip_pkg::*;

   localparam int DW = COORD_WIDTH + 1;
   localparam int PW = 2 * COORD_WIDTH;

   logic signed [DW-1:0] d_ay, d_bx, d_by, d_ax;
   logic [COORD_WIDTH-1:0] m_ay, m_bx, m_by, m_ax;
   logic [PW-1:0] prod_a, prod_b;
   logic ay_le, by_le, ax_lt, ax_gt, bx_lt, bx_gt, ax_eq, bx_eq;

   // differences carry one extra bit; magnitudes never exceed 2^W - 1
   assign d_ay = DW'(py) - DW'(ay);
   assign d_bx = DW'(bx) - DW'(px);
   assign d_by = DW'(by) - DW'(py);
   assign d_ax = DW'(px) - DW'(ax);

   assign m_ay = d_ay[DW-1] ? COORD_WIDTH'(-d_ay) : COORD_WIDTH'(d_ay);
   assign m_bx = d_bx[DW-1] ? COORD_WIDTH'(-d_bx) : COORD_WIDTH'(d_bx);
   assign m_by = d_by[DW-1] ? COORD_WIDTH'(-d_by) : COORD_WIDTH'(d_by);
   assign m_ax = d_ax[DW-1] ? COORD_WIDTH'(-d_ax) : COORD_WIDTH'(d_ax);

   assign prod_a = PW'(m_ay) * PW'(m_bx);
   assign prod_b = PW'(m_by) * PW'(m_ax);

   assign ay_le = (ay <= py);
   assign by_le = (by <= py);
   assign ax_lt = (ax < px);
   assign ax_gt = (ax > px);
   assign ax_eq = (ax == px);
   assign bx_lt = (bx < px);
   assign bx_gt = (bx > px);
   assign bx_eq = (bx == px);

   always_comb begin
      result = '0;
      if ((ay_le || by_le) && !((ax_lt && bx_lt) || (ax_gt && bx_gt))) begin
         if (!ax_eq && !bx_eq) begin
            if (!ay_le || !by_le) begin
               result.crossing = ay_le ? (prod_a > prod_b) : (prod_b > prod_a);
            end else begin
               result.crossing = 1'b1;
            end
         end else if (ax_gt) begin
            // half-open rule: endpoint on the ray counts from one side only
            result.crossing = by_le;
         end else if (bx_gt) begin
            result.crossing = ay_le;
         end else if (ax_eq && bx_eq) begin
            result.vertical = !ay_le || !by_le;
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/point_in_polygon_parity.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Crossing-number point-in-polygon test over a stream of vertices.
// Request channel (req_*): one beat per vertex. A beat with req_first_vertex
// samples the query point, clears the parity and the vertical-edge flag and
// tests no edge; every other beat tests the edge from the previous vertex.
// The closing vertex (repeated first vertex) carries req_last_vertex.
// Response channel (rsp_*): one beat per closing vertex, giving
// rsp_inside_res (odd crossings or on a vertical edge) and
// rsp_on_vertical_edge.
// The closing beat passes through the input register, then the edge test
// into the response register; a held response can stall it in between.
// Throughput: one vertex per cycle while req_stall is low; the edge test is two
// 16x16 multiplies and a compare between input register and parity state.
// Stall: only a closing vertex waits on a full response register, so
// req_stall rises only while rsp_stall holds a pending response and a closing
// vertex sits in the input register. Other vertices keep flowing.
// Reset (synchronous, active high): empties both registers and clears the
// previous vertex, the query point, the parity and the flag to zero.
module point_in_polygon_parity #(
   parameter int COORD_WIDTH = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [COORD_WIDTH-1:0] req_vertex_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_vertex_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_query_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_query_y,
   input  wire logic                          req_first_vertex,
   input  wire logic                          req_last_vertex,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_inside_res,
   output logic                               rsp_on_vertical_edge
);
   import pip_pkg::*;

   // stream state: previous vertex and sampled query point
   logic signed [COORD_WIDTH-1:0] prev_x_ff, prev_y_ff, qry_x_ff, qry_y_ff;
   logic signed [COORD_WIDTH-1:0] qry_x_in, qry_y_in;

   // input register: one complete edge A->B with its query point P
   logic                          s1_valid_ff;
   logic                          s1_first_ff, s1_last_ff;
   logic signed [COORD_WIDTH-1:0] s1_ax_ff, s1_ay_ff, s1_bx_ff, s1_by_ff;
   logic signed [COORD_WIDTH-1:0] s1_px_ff, s1_py_ff;

   // accumulated result
   logic parity_ff, parity_in;
   logic vert_ff, vert_in;

   // response register
   logic rsp_valid_ff, rsp_inside_ff, rsp_vert_ff;

   logic            req_take;
   logic            rsp_free;
   logic            s1_done;
   edge_result_type edge_res;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   // a non-closing vertex never needs the response register
   assign s1_done   = s1_valid_ff && (rsp_free || !s1_last_ff);
   assign req_stall = s1_valid_ff && !s1_done;
   assign req_take  = req_valid && !req_stall;

   // the first vertex brings its own query point along
   assign qry_x_in = req_first_vertex ? req_query_x : qry_x_ff;
   assign qry_y_in = req_first_vertex ? req_query_y : qry_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff <= '0;
         prev_y_ff <= '0;
         qry_x_ff  <= '0;
         qry_y_ff  <= '0;
      end else if (req_take) begin
         prev_x_ff <= req_vertex_x;
         prev_y_ff <= req_vertex_y;
         qry_x_ff  <= qry_x_in;
         qry_y_ff  <= qry_y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_done) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_first_ff <= req_first_vertex;
         s1_last_ff  <= req_last_vertex;
         s1_ax_ff    <= prev_x_ff;
         s1_ay_ff    <= prev_y_ff;
         s1_bx_ff    <= req_vertex_x;
         s1_by_ff    <= req_vertex_y;
         s1_px_ff    <= qry_x_in;
         s1_py_ff    <= qry_y_in;
      end
   end

   pip_edge_test #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_edge_test (
      .ax     (s1_ax_ff),
      .ay     (s1_ay_ff),
      .bx     (s1_bx_ff),
      .by     (s1_by_ff),
      .px     (s1_px_ff),
      .py     (s1_py_ff),
      .result (edge_res)
   );

   // first vertex restarts the count and tests no edge
   always_comb begin
      if (s1_first_ff) begin
         parity_in = 1'b0;
         vert_in   = 1'b0;
      end else begin
         parity_in = parity_ff ^ edge_res.crossing;
         vert_in   = vert_ff | edge_res.vertical;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parity_ff <= 1'b0;
         vert_ff   <= 1'b0;
      end else if (s1_done) begin
         parity_ff <= parity_in;
         vert_ff   <= vert_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_done && s1_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_done && s1_last_ff) begin
         rsp_inside_ff <= parity_in | vert_in;
         rsp_vert_ff   <= vert_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_inside_res       = rsp_inside_ff;
   assign rsp_on_vertical_edge = rsp_vert_ff;

   // a vertex that closes no polygon is never held back
   a_mid_no_stall: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_last_ff |-> !req_stall)
      else $error("non-closing vertex stalled the request channel");

   // back-pressure only comes from a held response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff && rsp_stall && s1_last_ff)
      else $error("request stalled without a held response");

   // a vertical-edge hit always reports inside
   a_vert_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_vert_ff |-> rsp_inside_ff)
      else $error("vertical-edge hit reported outside");

   // the accumulator is cleared by a first vertex
   a_first_clears: assert property (@(posedge clock) disable iff (reset)
      s1_done && s1_first_ff |=> !parity_ff && !vert_ff)
      else $error("first vertex did not clear the accumulator");

endmodule

`default_nettype wire
